/* design/mhd_pkg.sv */
`timescale 1ns / 1ps

package mhd_pkg;

    localparam int CORDIC_STEPS_DEF        = 16;
    localparam int ANGLE_FRACTION_BITS_DEF = 6;

    localparam int ANG_BITS  = 54;   // angle fraction bits (radians)
    localparam int VEC_SHIFT = 24;   // vector fraction bits
    localparam int SAMPLE_W  = 16;
    localparam int VEC_W     = 44;
    localparam int ANG_W     = 58;
    localparam int HEADING_W = 15;
    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 16;

    typedef logic signed [VEC_W-1:0] vec_t;
    typedef logic signed [ANG_W-1:0] angle_t;

    typedef struct packed {
        logic x_neg;
        logic y_zero;
    } flags_t;

    typedef struct packed {
        logic   valid;
        flags_t flags;
        angle_t z;
    } angle_beat_t;

    // Shift-subtract division, elaboration time only.
    function automatic logic [63:0] const_udiv(logic [63:0] n, logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] q;
        rem = '0;
        q   = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d}) begin
                rem  = rem - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n), truncated series
    function automatic logic [63:0] atan_inv(logic [63:0] n);
        logic [63:0] p;
        logic [63:0] n2;
        logic [63:0] sum;
        logic [63:0] term;
        p   = const_udiv(64'd1 << ANG_BITS, n);
        n2  = n * n;
        sum = '0;
        for (int k = 0; k < 40; k++) begin
            if (p != 64'd0) begin
                term = const_udiv(p, 64'(2 * k + 1));
                sum  = k[0] ? sum - term : sum + term;
                p    = const_udiv(p, n2);
            end
        end
        return sum;
    endfunction

    // atan(2^-i), i >= 1
    function automatic logic [63:0] atan_pow2(int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          e;
        sum = '0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e <= ANG_BITS) begin
                term = const_udiv(64'd1 << (ANG_BITS - e), 64'(2 * k + 1));
                sum  = k[0] ? sum - term : sum + term;
            end
        end
        return sum;
    endfunction

    // Machin's formula
    localparam logic [63:0] QUARTER_PI_U = 64'd4 * atan_inv(64'd5) - atan_inv(64'd239);
    localparam angle_t      PI_FIX       = ANG_W'(QUARTER_PI_U << 2);

    function automatic angle_t atan_entry(int i);
        if (i == 0) begin
            return ANG_W'(QUARTER_PI_U);
        end
        return ANG_W'(atan_pow2(i));
    endfunction

endpackage

/* design/mhd_skid.sv */
`timescale 1ns / 1ps

module mhd_skid #(
    parameter int W = mhd_pkg::S_TDATA_W
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  logic [W-1:0] in_data,
    input  logic         en,
    output logic         out_valid,
    output logic [W-1:0] out_data
);
    import mhd_pkg::*;

    logic         skid_valid_reg;
    logic [W-1:0] skid_data_reg;

    assign in_ready  = !skid_valid_reg;
    assign out_valid = skid_valid_reg || in_valid;
    assign out_data  = skid_valid_reg ? skid_data_reg : in_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            skid_valid_reg <= 1'b0;
        end else if (en) begin
            skid_valid_reg <= 1'b0;
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    // catch one transaction while the pipe is held
    always_ff @(posedge aclk) begin
        if (!en && in_valid && !skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    a_skid_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg && !en |=> skid_valid_reg && $stable(skid_data_reg))
        else $error("skid entry lost or overwritten while held");

endmodule

/* design/mhd_cordic.sv */
`timescale 1ns / 1ps

module mhd_cordic #(
    parameter int CORDIC_STEPS = mhd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [mhd_pkg::SAMPLE_W-1:0]  x_raw,
    input  logic [mhd_pkg::SAMPLE_W-1:0]  y_raw,
    output mhd_pkg::angle_beat_t          out_beat
);
    import mhd_pkg::*;

    logic [CORDIC_STEPS:0] vld_reg;
    vec_t                  x_reg [CORDIC_STEPS+1];
    vec_t                  y_reg [CORDIC_STEPS+1];
    angle_t                z_reg [CORDIC_STEPS+1];
    flags_t                flg_reg [CORDIC_STEPS+1];

    vec_t                  x_next [CORDIC_STEPS];
    vec_t                  y_next [CORDIC_STEPS];
    angle_t                z_next [CORDIC_STEPS];

    logic signed [SAMPLE_W-1:0] xs;
    logic signed [SAMPLE_W-1:0] ys;
    vec_t                       x0_next;
    vec_t                       y0_next;
    angle_t                     z0_next;
    flags_t                     f0_next;

    // left half plane: turn by pi, sign of the turn from y
    always_comb begin
        xs      = signed'(x_raw);
        ys      = signed'(y_raw);
        x0_next = VEC_W'(xs) <<< VEC_SHIFT;
        y0_next = VEC_W'(ys) <<< VEC_SHIFT;
        z0_next = '0;
        if (xs[SAMPLE_W-1]) begin
            x0_next = -x0_next;
            y0_next = -y0_next;
            z0_next = (ys > 0) ? PI_FIX : -PI_FIX;
        end
        f0_next.x_neg  = xs[SAMPLE_W-1];
        f0_next.y_zero = (ys == '0);
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
        localparam angle_t ATAN_I = atan_entry(i);
        logic rot_pos;
        vec_t dx;
        vec_t dy;
        assign rot_pos   = (y_reg[i] > 0);
        assign dx        = y_reg[i] >>> i;
        assign dy        = x_reg[i] >>> i;
        assign x_next[i] = rot_pos ? x_reg[i] + dx : x_reg[i] - dx;
        assign y_next[i] = rot_pos ? y_reg[i] - dy : y_reg[i] + dy;
        assign z_next[i] = rot_pos ? z_reg[i] + ATAN_I : z_reg[i] - ATAN_I;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[CORDIC_STEPS-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= x0_next;
            y_reg[0]   <= y0_next;
            z_reg[0]   <= z0_next;
            flg_reg[0] <= f0_next;
            for (int j = 0; j < CORDIC_STEPS; j++) begin
                x_reg[j+1]   <= x_next[j];
                y_reg[j+1]   <= y_next[j];
                z_reg[j+1]   <= z_next[j];
                flg_reg[j+1] <= flg_reg[j];
            end
        end
    end

    assign out_beat.valid = vld_reg[CORDIC_STEPS];
    assign out_beat.flags = flg_reg[CORDIC_STEPS];
    assign out_beat.z     = z_reg[CORDIC_STEPS];

    a_prep_right_half: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[0] |-> !x_reg[0][VEC_W-1])
        else $error("prep stage left x negative");

    a_x_nonneg: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[CORDIC_STEPS] |-> !x_reg[CORDIC_STEPS][VEC_W-1])
        else $error("vectoring x went negative or overflowed");

endmodule

/* design/mhd_scale.sv */
`timescale 1ns / 1ps

module mhd_scale #(
    parameter int ANGLE_FRACTION_BITS = mhd_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           en,
    input  mhd_pkg::angle_beat_t           in_beat,
    output logic                           out_valid,
    output logic [mhd_pkg::HEADING_W-1:0]  heading
);
    import mhd_pkg::*;

    localparam int F     = ANGLE_FRACTION_BITS;
    localparam int QB    = F + 10;          // quotient bits, holds 360 * 2^(F+1)
    localparam int U_W   = ANG_W - 1;
    localparam int NUM_W = U_W + 6;
    localparam int REM_W = NUM_W + F + 1;
    localparam int PIPE_N = QB + 3;

    localparam logic [QB-1:0] FULL   = QB'(360) << F;
    localparam logic [QB-1:0] HALF   = QB'(180) << F;
    localparam logic [QB-1:0] Q_MAX  = QB'(360) << (F + 1);

    logic [PIPE_N-1:0] vld_reg;
    flags_t            flg_reg [PIPE_N];
    angle_t            zc_reg;
    logic [U_W-1:0]    u_reg;
    logic [REM_W-1:0]  rem_reg [QB+1];
    logic [QB-1:0]     q_reg   [QB+1];
    logic [REM_W-1:0]  rem_next [QB];
    logic [QB-1:0]     q_next   [QB];

    angle_t            zc_next;
    logic [U_W-1:0]    u_next;
    logic [NUM_W-1:0]  num_next;
    logic [QB:0]       q_inc;
    logic [QB-1:0]     res_next;
    flags_t            flg_last;

    logic              out_valid_reg;
    logic [HEADING_W-1:0] heading_reg;

    always_comb begin
        zc_next = in_beat.z;
        if (in_beat.z > PI_FIX) begin
            zc_next = PI_FIX;
        end else if (in_beat.z < -PI_FIX) begin
            zc_next = -PI_FIX;
        end
    end

    assign u_next = U_W'(zc_reg + PI_FIX);

    // x45 as shift-add
    assign num_next = (NUM_W'(u_reg) << 5) + (NUM_W'(u_reg) << 3)
                    + (NUM_W'(u_reg) << 2) + NUM_W'(u_reg);

    // restoring divide by pi/4, one quotient bit per stage, MSB first
    for (genvar k = 0; k < QB; k++) begin : g_div
        localparam int B = QB - 1 - k;
        localparam logic [REM_W-1:0] TRIAL = REM_W'(QUARTER_PI_U) << B;
        logic take;
        assign take        = (rem_reg[k] >= TRIAL);
        assign rem_next[k] = take ? rem_reg[k] - TRIAL : rem_reg[k];
        assign q_next[k]   = q_reg[k] | (QB'(take) << B);
    end

    // round half up, clamp, special cases
    assign flg_last = flg_reg[PIPE_N-1];
    always_comb begin
        q_inc    = {1'b0, q_reg[QB]} + (QB+1)'(1);
        res_next = q_inc[QB:1];
        if (res_next > FULL) begin
            res_next = FULL;
        end
        if (flg_last.y_zero) begin
            res_next = flg_last.x_neg ? FULL : HALF;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[PIPE_N-2:0], in_beat.valid};
            out_valid_reg <= vld_reg[PIPE_N-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            flg_reg[0] <= in_beat.flags;
            for (int j = 0; j < PIPE_N - 1; j++) begin
                flg_reg[j+1] <= flg_reg[j];
            end
            zc_reg     <= zc_next;
            u_reg      <= u_next;
            rem_reg[0] <= REM_W'(num_next) << (F + 1);
            q_reg[0]   <= '0;
            for (int j = 0; j < QB; j++) begin
                rem_reg[j+1] <= rem_next[j];
                q_reg[j+1]   <= q_next[j];
            end
            heading_reg <= HEADING_W'(res_next);
        end
    end

    assign out_valid = out_valid_reg;
    assign heading   = heading_reg;

    a_quot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[PIPE_N-1] |-> q_reg[QB] <= Q_MAX)
        else $error("divider quotient beyond full circle");

endmodule

/* design/magnetometer_heading_unit.sv */
`timescale 1ns / 1ps

// Compass heading from one magnetometer X/Y sample.
// Slave stream: one transaction carries the raw big-endian X and Y bytes.
// Master stream: one transaction per input with the heading, atan2(y,x) + 180
// degrees in units of 1/2^ANGLE_FRACTION_BITS degree (0..23040 by default).
// Stages: one prep stage, one stage per CORDIC iteration, three scaling stages, one
// restoring-divide stage per quotient bit, one rounding/output stage.
// Throughput: one transaction per cycle while the master side is not stalled;
// every stage holds a single item.
// Stall: while m_tvalid is high and m_tready low the whole pipe holds and the
// input register takes one more transaction, then s_tready drops. s_tready
// comes straight from a flop.
// Reset: synchronous, active low; clears all valid bits, so nothing is
// presented on the master side until new samples arrive.
module magnetometer_heading_unit #(
    parameter int CORDIC_STEPS        = mhd_pkg::CORDIC_STEPS_DEF,
    parameter int ANGLE_FRACTION_BITS = mhd_pkg::ANGLE_FRACTION_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [mhd_pkg::S_TDATA_W-1:0]   s_tdata,  // x_high, x_low, y_high, y_low
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [mhd_pkg::M_TDATA_W-1:0]   m_tdata   // heading[14:0], zero pad
);
    import mhd_pkg::*;

    logic                 en;
    logic                 pipe_valid;
    logic [S_TDATA_W-1:0] pipe_data;
    logic [SAMPLE_W-1:0]  x_raw;
    logic [SAMPLE_W-1:0]  y_raw;
    angle_beat_t          cordic_beat;
    logic                 out_valid;
    logic [HEADING_W-1:0] heading;

    assign en = !out_valid || m_tready;

    mhd_skid #(
        .W (S_TDATA_W)
    ) u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .en        (en),
        .out_valid (pipe_valid),
        .out_data  (pipe_data)
    );

    assign x_raw = {pipe_data[7:0], pipe_data[15:8]};
    assign y_raw = {pipe_data[23:16], pipe_data[31:24]};

    mhd_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (pipe_valid),
        .x_raw    (x_raw),
        .y_raw    (y_raw),
        .out_beat (cordic_beat)
    );

    mhd_scale #(
        .ANGLE_FRACTION_BITS (ANGLE_FRACTION_BITS)
    ) u_scale (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_beat   (cordic_beat),
        .out_valid (out_valid),
        .heading   (heading)
    );

    assign m_tvalid = out_valid;
    assign m_tdata  = M_TDATA_W'(heading);

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;

    localparam int STEPS       = mhd_pkg::CORDIC_STEPS_DEF;
    localparam int FRAC        = mhd_pkg::ANGLE_FRACTION_BITS_DEF;
    localparam int PIPE_DEPTH  = STEPS + FRAC + 15;
    localparam int RAD_FRAC    = 54;   // angle fraction bits
    localparam int VEC_FRAC    = 24;   // vector fraction bits
    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 400;

    localparam longint unsigned FULL_TURN = 64'd360 << FRAC;
    localparam longint unsigned HALF_TURN = 64'd180 << FRAC;

    // tdata layout, lowest bits first: x_high, x_low, y_high, y_low
    typedef struct packed {
        logic [7:0] y_low;
        logic [7:0] y_high;
        logic [7:0] x_low;
        logic [7:0] x_high;
    } sample_t;

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [mhd_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [mhd_pkg::M_TDATA_W-1:0] m_tdata;

    sample_t    pending_q[$];
    logic [14:0] expected_heading_q[$];
    logic [14:0] heading_want;

    longint atan_steps[STEPS];
    longint quarter_pi_fix;

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int ready_hold_left = 0;
    int err_count       = 0;
    int sent_count      = 0;
    int checked_count   = 0;
    int axis_count      = 0;
    int left_count      = 0;
    int stall_count     = 0;
    int cycle_count     = 0;

    magnetometer_heading_unit u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // atan(1/n) by alternating series, n >= 2
    function automatic longint series_atan_inv(longint unsigned n);
        longint unsigned p;
        longint unsigned term;
        longint          sum;
        int              k;
        p   = (64'd1 << RAD_FRAC) / n;
        sum = 0;
        k   = 0;
        while (p != 0) begin
            term = p / longint'(2 * k + 1);
            sum  = (k % 2 != 0) ? sum - longint'(term) : sum + longint'(term);
            p    = p / (n * n);
            k++;
        end
        return sum;
    endfunction

    // atan(2^-i), i >= 1
    function automatic longint series_atan_pow2(int i);
        longint sum;
        longint term;
        int     e;
        sum = 0;
        for (int k = 0; k < 64; k++) begin
            e = i * (2 * k + 1);
            if (e > RAD_FRAC) break;
            term = longint'((64'd1 << (RAD_FRAC - e)) / longint'(2 * k + 1));
            sum  = (k % 2 != 0) ? sum - term : sum + term;
        end
        return sum;
    endfunction

    function automatic void build_atan_steps();
        quarter_pi_fix = 4 * series_atan_inv(5) - series_atan_inv(239);
        for (int i = 0; i < STEPS; i++) begin
            atan_steps[i] = (i == 0) ? quarter_pi_fix : series_atan_pow2(i);
        end
    endfunction

    function automatic logic [14:0] heading_of(sample_t smp);
        longint          xs;
        longint          ys;
        longint          xv;
        longint          yv;
        longint          zv;
        longint          dx;
        longint          dy;
        longint          pi_fix;
        longint unsigned num;
        longint unsigned den;
        longint unsigned q;
        longint unsigned rem;
        longint unsigned res;
        xs = longint'($signed({smp.x_high, smp.x_low}));
        ys = longint'($signed({smp.y_high, smp.y_low}));
        if (ys == 0) begin
            res = (xs < 0) ? FULL_TURN : HALF_TURN;
            return res[14:0];
        end
        pi_fix = 4 * quarter_pi_fix;
        xv = xs <<< VEC_FRAC;
        yv = ys <<< VEC_FRAC;
        zv = 0;
        // left half plane: pre-rotate by pi, direction from sign of y
        if (xv < 0) begin
            xv = -xv;
            yv = -yv;
            zv = (ys > 0) ? pi_fix : -pi_fix;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0) begin
                xv = xv + dx;
                yv = yv - dy;
                zv = zv + atan_steps[i];
            end else begin
                xv = xv - dx;
                yv = yv + dy;
                zv = zv - atan_steps[i];
            end
        end
        if (zv > pi_fix) zv = pi_fix;
        if (zv < -pi_fix) zv = -pi_fix;
        num = zv + pi_fix;
        num = num * 64'd45;
        den = quarter_pi_fix;
        q   = num / den;
        rem = num % den;
        // one extra quotient bit for round half up
        for (int i = 0; i <= FRAC; i++) begin
            q   = q << 1;
            rem = rem << 1;
            if (rem >= den) begin
                rem = rem - den;
                q   = q + 1;
            end
        end
        res = (q + 1) >> 1;
        if (res > FULL_TURN) res = FULL_TURN;
        return res[14:0];
    endfunction

    function automatic sample_t pack_sample(logic [15:0] xv, logic [15:0] yv);
        sample_t smp;
        smp.x_high = xv[15:8];
        smp.x_low  = xv[7:0];
        smp.y_high = yv[15:8];
        smp.y_low  = yv[7:0];
        return smp;
    endfunction

    function automatic sample_t random_sample();
        logic [15:0] xv;
        logic [15:0] yv;
        int          mode;
        mode = $urandom_range(11);
        xv   = 16'($urandom);
        yv   = 16'($urandom);
        case (mode)
            0: begin
                xv = 16'($urandom_range(8)) - 16'd4;
                yv = 16'($urandom_range(8)) - 16'd4;
            end
            1: yv = '0;
            2: xv = '0;
            3: begin
                // near the negative x axis, where the heading wraps
                xv = 16'h8000 | 16'($urandom_range(16'h7fff));
                yv = 16'($urandom_range(4)) - 16'd2;
            end
            4: yv = xv;
            5: yv = -xv;
            default: ;
        endcase
        return pack_sample(xv, yv);
    endfunction

    task automatic wait_drained();
        do @(negedge aclk);
        while (pending_q.size() != 0 || s_tvalid || expected_heading_q.size() != 0);
    endtask

    task automatic queue_random(int count);
        for (int i = 0; i < count; i++) begin
            pending_q.push_back(random_sample());
        end
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                expected_heading_q.push_back(heading_of(sample_t'(s_tdata)));
                sent_count++;
                if (s_tdata[31:16] == 16'd0) axis_count++;
                if (s_tdata[7]) left_count++;
            end
            if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_q.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (ready_hold_left > 0) begin
            ready_hold_left--;
            if (s_tvalid && !s_tready) stall_count++;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // monitor
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_heading_q.size() == 0) begin
                $error("heading: no transaction expected, actual %0d", m_tdata[14:0]);
                err_count++;
            end else begin
                heading_want = expected_heading_q.pop_front();
                checked_count++;
                if (m_tdata[14:0] !== heading_want) begin
                    $error("heading: expected %0d, actual %0d", heading_want, m_tdata[14:0]);
                    err_count++;
                end
                if (m_tdata[15] !== 1'b0) begin
                    $error("pad: expected 0, actual %b", m_tdata[15]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [15:0] corner_x[23];
        logic [15:0] corner_y[23];
        corner_x = '{16'h0000, 16'h7fff, 16'h8000, 16'hffff, 16'h0001, 16'h0000, 16'h0000,
                     16'h0000, 16'h0000, 16'h0001, 16'hffff, 16'hffff, 16'h0001, 16'h7fff,
                     16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h0001, 16'h0001,
                     16'h00ff, 16'h5a5a};
        corner_y = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7fff, 16'h8000,
                     16'h0001, 16'hffff, 16'h0001, 16'h0001, 16'hffff, 16'hffff, 16'h7fff,
                     16'h8000, 16'h7fff, 16'h8000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000,
                     16'hff00, 16'ha5a5};
        build_atan_steps();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        @(negedge aclk);
        send_idle_pct = 27;
        recv_idle_pct = 80;
        for (int i = 0; i < 23; i++) begin
            pending_q.push_back(pack_sample(corner_x[i], corner_y[i]));
        end
        wait_drained();
        queue_random(330);
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 27;
        queue_random(350);
        wait_drained();

        // long output stall with the input kept busy
        send_idle_pct   = 0;
        recv_idle_pct   = 0;
        ready_hold_left = HOLD_CYCLES;
        queue_random(100);
        wait_drained();

        queue_random(400);
        wait_drained();

        repeat (PIPE_DEPTH + 8) @(negedge aclk);
        $display("Sent %0d samples (%0d with y = 0, %0d with x < 0), checked %0d headings.",
                 sent_count, axis_count, left_count, checked_count);
        $display("Input held off by output stall for %0d cycles.", stall_count);
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
